>>> src/hss_pkg.sv
// hss_pkg: opcodes, register indexes and fixed field widths of the hop sync sequencer.
// Used by hop_sync_sequencer_unit and hss_checker; depends on nothing.
`default_nettype none

package hss_pkg;

    localparam int OPCODE_BITS = 2;
    localparam int TAG_BITS    = 4;
    localparam int COUNT_BITS  = 16;
    localparam int THRESH_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;

    typedef logic [OPCODE_BITS-1:0]    opcode_t;
    typedef logic [TAG_BITS-1:0]       tag_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [THRESH_BITS-1:0]    thresh_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam opcode_t OP_TICK    = 2'd0;
    localparam opcode_t OP_PACKET  = 2'd1;
    localparam opcode_t OP_IRQ_END = 2'd2;

    localparam cfg_index_t CFG_TELEMETRY_ENABLE = 1'b0;
    localparam cfg_index_t CFG_LOSS_THRESHOLD   = 1'b1;

    localparam thresh_t THRESH_RESET = 16'd1000;
    localparam tag_t    TAG_ONE      = 4'd1;
    localparam count_t  COUNT_ONE    = 16'd1;

    // miss count reset value before truncation to the miss counter width
    localparam logic [31:0] MISS_RESET_RAW = 32'd99999;

    // while sync is lost, hop only on every LOST_HOP_DIVISOR-th miss
    localparam int LOST_HOP_DIVISOR = 50;
    localparam int MOD_BITS = 6;
    typedef logic [MOD_BITS-1:0] mod_t;
    localparam mod_t MOD_LAST = 6'(LOST_HOP_DIVISOR - 1);
    localparam mod_t MOD_ONE  = 6'd1;

endpackage

`default_nettype wire

>>> src/hop_sync_sequencer_unit.sv
// Hop sync sequencer: event-driven sync controller of a frequency-hopping receiver.
// Takes types from hss_pkg. Bound to hss_checker for assertions.
//
// Usage:
//   Input stream (s_*): one event per transfer; s_tuser carries the opcode
//   (timer tick, valid packet, interrupt end), s_tdata the packet position,
//   ack tag, telemetry-available and radio-active flags.
//   Result stream (m_*): exactly one status result per event, in order:
//   retune request, tuned position, transmit slot, downlink tag, counters.
//   Config port: cfg_we/cfg_index/cfg_wdata, to be written only while idle; the block does not enforce this.
// Path: an accepted event is captured in the input register, then one pass of
//   logic carries it into the result register.
// Throughput: one event per cycle while the result stream is not stalled; the state
//   update is a single registered pass, so events follow back to back.
// Stall: while m_tready is low the result holds; one more event is taken into
//   the input register, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, state returns to its
//   power-up values (out of sync, hop position all ones, telemetry disabled).
`default_nettype none

module hop_sync_sequencer_unit #(
    parameter int POSITION_BITS = 16,
    parameter int MISS_BITS     = 20
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration
    input  wire logic                                  cfg_we,
    input  wire hss_pkg::cfg_index_t                   cfg_index,
    input  wire hss_pkg::cfg_data_t                    cfg_wdata,
    // event stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // s_tdata: packet_position, packet_ack_tag, telemetry_available,
    //          radio_active, zero pad
    input  wire logic [((POSITION_BITS+6+7)/8)*8-1:0]  s_tdata,
    // s_tuser: opcode
    input  wire hss_pkg::opcode_t                      s_tuser,
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata: retune, tune_position, transmit_slot, downlink_tag, new_downlink,
    //          sync_lost, missed_slots, acks_seen, nacks_seen, stale_acks_seen, pad
    output logic [((POSITION_BITS+MISS_BITS+56+7)/8)*8-1:0] m_tdata
);
    import hss_pkg::*;

    localparam int OUT_FIELD_BITS = POSITION_BITS + MISS_BITS + 56;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CMP_BITS = (MISS_BITS > THRESH_BITS) ? MISS_BITS : THRESH_BITS;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [MISS_BITS-1:0]     miss_t;

    localparam pos_t  POS_ONE    = POSITION_BITS'(1);
    localparam pos_t  POS_RESET  = '1;
    localparam miss_t MISS_MAX   = '1;
    localparam miss_t MISS_ONE   = MISS_BITS'(1);
    localparam miss_t MISS_RESET = MISS_RESET_RAW[MISS_BITS-1:0];
    localparam mod_t  MOD_RESET  = MOD_BITS'(MISS_RESET % LOST_HOP_DIVISOR);

    // configuration registers
    logic    tel_en_reg;
    thresh_t thresh_reg;

    // input stage
    logic    in_valid_reg;
    opcode_t in_op_reg;
    pos_t    in_pos_reg;
    tag_t    in_ack_reg;
    logic    in_avail_reg;
    logic    in_radio_reg;

    // sync state
    pos_t   hop_reg, hop_next;
    miss_t  miss_reg, miss_next;
    mod_t   mod_reg, mod_next;
    pos_t   prearm_pos_reg, prearm_pos_next;
    logic   prearm_v_reg, prearm_v_next;
    pos_t   resync_pos_reg, resync_pos_next;
    logic   resync_v_reg, resync_v_next;
    tag_t   tag_reg, tag_next;
    logic   free_reg, free_next;
    count_t ack_reg, ack_next;
    count_t nack_reg, nack_next;
    count_t stale_reg, stale_next;

    // result stage
    logic   out_valid_reg;
    logic   out_retune_reg, res_retune;
    pos_t   out_tune_reg, res_tune;
    logic   out_tx_reg, res_tx;
    logic   out_new_reg, res_new;
    logic   out_lost_reg, res_lost;

    logic   advance;
    logic   fire;
    logic   rx_slot;
    logic   goto_req;
    pos_t   goto_target;
    logic   goto_pv;

    function automatic logic is_lost(input miss_t m, input thresh_t t);
        return CMP_BITS'(m) > CMP_BITS'(t);
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tel_en_reg <= 1'b0;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TELEMETRY_ENABLE: tel_en_reg <= cfg_wdata[0];
                CFG_LOSS_THRESHOLD:   thresh_reg <= cfg_wdata[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_pos_reg   <= s_tdata[POSITION_BITS-1:0];
            in_ack_reg   <= s_tdata[POSITION_BITS +: TAG_BITS];
            in_avail_reg <= s_tdata[POSITION_BITS+4];
            in_radio_reg <= s_tdata[POSITION_BITS+5];
        end
    end

    always_comb begin
        hop_next        = hop_reg;
        miss_next       = miss_reg;
        mod_next        = mod_reg;
        prearm_pos_next = prearm_pos_reg;
        prearm_v_next   = prearm_v_reg;
        resync_pos_next = resync_pos_reg;
        resync_v_next   = resync_v_reg;
        tag_next        = tag_reg;
        free_next       = free_reg;
        ack_next        = ack_reg;
        nack_next       = nack_reg;
        stale_next      = stale_reg;
        res_retune      = 1'b0;
        res_tune        = '0;
        res_tx          = 1'b0;
        res_new         = 1'b0;
        goto_req        = 1'b0;
        goto_target     = hop_reg + POS_ONE;
        goto_pv         = prearm_v_reg;
        rx_slot = !hop_reg[0] || is_lost(miss_reg, thresh_reg) || !tel_en_reg;

        unique case (in_op_reg)
            OP_TICK: begin
                if (rx_slot && miss_reg != MISS_MAX) begin
                    miss_next = miss_reg + MISS_ONE;
                    mod_next  = (mod_reg == MOD_LAST) ? '0 : mod_reg + MOD_ONE;
                end
                if (!is_lost(miss_next, thresh_reg) || mod_next == '0) begin
                    goto_req = 1'b1;
                end
            end
            OP_PACKET: begin
                resync_pos_next = in_pos_reg + POS_ONE;
                resync_v_next   = 1'b1;
                if (in_ack_reg == tag_reg) begin
                    ack_next  = ack_reg + COUNT_ONE;
                    free_next = 1'b1;
                end else if (in_ack_reg == tag_reg - TAG_ONE) begin
                    nack_next = nack_reg + COUNT_ONE;
                end else begin
                    stale_next = stale_reg + COUNT_ONE;
                end
            end
            OP_IRQ_END: begin
                prearm_v_next = 1'b0;
                if (resync_v_reg) begin
                    resync_v_next = 1'b0;
                    miss_next     = '0;
                    mod_next      = '0;
                    goto_req      = 1'b1;
                    goto_target   = resync_pos_reg;
                    goto_pv       = 1'b0;
                end else begin
                    prearm_pos_next = hop_reg + POS_ONE;
                    prearm_v_next   = 1'b1;
                    res_retune      = 1'b1;
                    res_tune        = hop_reg + POS_ONE;
                end
            end
            default: ;
        endcase

        if (goto_req) begin
            hop_next = goto_target;
            if (!(goto_pv && goto_target == prearm_pos_reg && in_radio_reg)) begin
                res_retune = 1'b1;
                res_tune   = goto_target;
                if (goto_target[0] && !is_lost(miss_next, thresh_reg) && tel_en_reg) begin
                    res_tx = 1'b1;
                    if (free_reg && in_avail_reg) begin
                        tag_next  = tag_reg + TAG_ONE;
                        free_next = 1'b0;
                        res_new   = 1'b1;
                    end
                end
            end
        end

        res_lost = is_lost(miss_next, thresh_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_reg        <= POS_RESET;
            miss_reg       <= MISS_RESET;
            mod_reg        <= MOD_RESET;
            prearm_pos_reg <= '0;
            prearm_v_reg   <= 1'b0;
            resync_pos_reg <= '0;
            resync_v_reg   <= 1'b0;
            tag_reg        <= '0;
            free_reg       <= 1'b1;
            ack_reg        <= '0;
            nack_reg       <= '0;
            stale_reg      <= '0;
        end else if (fire) begin
            hop_reg        <= hop_next;
            miss_reg       <= miss_next;
            mod_reg        <= mod_next;
            prearm_pos_reg <= prearm_pos_next;
            prearm_v_reg   <= prearm_v_next;
            resync_pos_reg <= resync_pos_next;
            resync_v_reg   <= resync_v_next;
            tag_reg        <= tag_next;
            free_reg       <= free_next;
            ack_reg        <= ack_next;
            nack_reg       <= nack_next;
            stale_reg      <= stale_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            out_retune_reg <= res_retune;
            out_tune_reg   <= res_tune;
            out_tx_reg     <= res_tx;
            out_new_reg    <= res_new;
            out_lost_reg   <= res_lost;
        end
    end

    // counters and tag are read straight from state, which moves only on the next transfer
    logic [OUT_FIELD_BITS-1:0] out_fields;
    assign out_fields = {stale_reg, nack_reg, ack_reg, miss_reg, out_lost_reg, out_new_reg,
                         tag_reg, out_tx_reg, out_tune_reg, out_retune_reg};
    assign m_tdata = OUT_DATA_BITS'(out_fields);

endmodule

`default_nettype wire

>>> src/hss_checker.sv
// hss_checker: port-level assertions for hop_sync_sequencer_unit, attached by bind.
// Depends on hss_pkg and on the top level's port layout.
`default_nettype none

module hss_checker #(
    parameter int POSITION_BITS = 16,
    parameter int MISS_BITS     = 20
) (
    input wire logic                                           aclk,
    input wire logic                                           aresetn,
    input wire logic                                           s_tready,
    input wire logic                                           m_tvalid,
    input wire logic                                           m_tready,
    input wire logic [((POSITION_BITS+MISS_BITS+56+7)/8)*8-1:0] m_tdata
);
    import hss_pkg::*;

    localparam int TX_BIT  = POSITION_BITS + 1;
    localparam int NEW_BIT = POSITION_BITS + 6;

    logic                     f_retune;
    logic [POSITION_BITS-1:0] f_tune;
    logic                     f_tx;
    logic                     f_new;

    assign f_retune = m_tdata[0];
    assign f_tune   = m_tdata[POSITION_BITS:1];
    assign f_tx     = m_tdata[TX_BIT];
    assign f_new    = m_tdata[NEW_BIT];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_retune_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !f_retune |-> f_tune == '0 && !f_tx && !f_new)
        else $error("tune fields set without retune");

    a_new_needs_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && f_new |-> f_tx && f_retune)
        else $error("new downlink outside a transmit slot");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

endmodule

bind hop_sync_sequencer_unit hss_checker #(
    .POSITION_BITS(POSITION_BITS),
    .MISS_BITS(MISS_BITS)
) u_hss_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
